@@ rtl/pfe_pkg.sv @@
// Shared types, codes and constants of the palette fade engine.
`default_nettype none

package pfe_pkg;

  localparam int PFE_PALETTE_ENTRIES = 64;

  // Widest span a fade range can cover
  localparam int SPAN_CAP = 64;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [1:0] BANK_WORK_A = 2'd0;
  localparam logic [1:0] BANK_WORK_B = 2'd2;

  localparam logic [1:0] SEL_FADE_IN   = 2'd0;
  localparam logic [1:0] SEL_FADE_OUT  = 2'd1;
  localparam logic [1:0] SEL_FLASH_IN  = 2'd2;
  localparam logic [1:0] SEL_FLASH_OUT = 2'd3;

  localparam logic [7:0] CH_STEP  = 8'd32;
  localparam logic [7:0] CH_WHITE = 8'd224;
  localparam logic [4:0] LAST_STEP = 5'd21;
  localparam logic [5:0] FULL_SPAN_OFFSET = 6'd63;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_FADE_IN   = 3'd1,
    MODE_FADE_OUT  = 3'd2,
    MODE_FLASH_IN  = 3'd3,
    MODE_FLASH_OUT = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

@@ rtl/pfe_if.sv @@
// Valid/ready channel interfaces of the palette fade engine.
`default_nettype none

interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] bank;
  logic [5:0] entry_index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [1:0] mode_sel;
  logic [5:0] range_first;
  logic [5:0] range_last_offset;

  modport source (output valid, func, bank, entry_index, red_in, green_in, blue_in,
                  mode_sel, range_first, range_last_offset, input ready);
  modport sink (input valid, func, bank, entry_index, red_in, green_in, blue_in,
                mode_sel, range_first, range_last_offset, output ready);
endinterface

interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic       done_res;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, done_res, red_out, green_out, blue_out, input ready);
  modport sink (input valid, done_res, red_out, green_out, blue_out, output ready);
endinterface

interface pfe_cfg_if;
  logic valid;
  logic ready;
  logic dual_bank_enable;

  modport source (output valid, dual_bank_enable, input ready);
  modport sink (input valid, dual_bank_enable, output ready);
endinterface

`default_nettype wire

@@ rtl/pfe_step_unit.sv @@
// Shared colour step unit: moves one channel of an entry by one fade step.
`default_nettype none

module pfe_step_unit import pfe_pkg::*; (
  input  mode_t mode,
  input  rgb_t  work,
  input  rgb_t  target,
  output rgb_t  stepped
);

  always_comb begin
    stepped = work;
    case (mode)
      MODE_FADE_IN: begin
        // raise the first channel below target, blue first
        if (target.blue > work.blue) begin
          stepped.blue = work.blue + CH_STEP;
        end else if (target.green > work.green) begin
          stepped.green = work.green + CH_STEP;
        end else if (target.red > work.red) begin
          stepped.red = work.red + CH_STEP;
        end
      end
      MODE_FLASH_IN: begin
        // lower the first channel above target, blue first
        if (target.blue < work.blue) begin
          stepped.blue = work.blue - CH_STEP;
        end else if (target.green < work.green) begin
          stepped.green = work.green - CH_STEP;
        end else if (target.red < work.red) begin
          stepped.red = work.red - CH_STEP;
        end
      end
      MODE_FADE_OUT: begin
        // drop the first lit channel, red first
        if (work.red != 8'd0) begin
          stepped.red = work.red - CH_STEP;
        end else if (work.green != 8'd0) begin
          stepped.green = work.green - CH_STEP;
        end else if (work.blue != 8'd0) begin
          stepped.blue = work.blue - CH_STEP;
        end
      end
      MODE_FLASH_OUT: begin
        // push the first channel short of white, red first
        if (work.red != CH_WHITE) begin
          stepped.red = work.red + CH_STEP;
        end else if (work.green != CH_WHITE) begin
          stepped.green = work.green + CH_STEP;
        end else if (work.blue != CH_WHITE) begin
          stepped.blue = work.blue + CH_STEP;
        end
      end
      default: begin
        stepped = work;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/palette_fade_engine.sv @@
// Top level of the palette fade engine: palette store, sequencer and result register.
//
//   channel   dir  handshake          word
//   in_chan   in   valid/ready        func, bank, entry, colour, mode, fade range
//   out_chan  out  valid/ready        done flag and read colour
//   cfg_chan  in   valid/ready (=1)   dual_bank_enable
//
// A load and a start without fill go straight to the result stage, a read by way
// of the read wait state. A fade-in or flash-in start walks its span once, one entry
// a cycle (up to 64 entries). A tick walks working A and, where needed, working B
// through the step unit, one entry a cycle with the store read and write-back overlapped.
// Reset is synchronous, active low, and clears control state only; the store keeps
// no reset. A stalled result holds in the output register and the next word is
// still taken; the sequencer waits at its last state only while that register is full.
`default_nettype none

module palette_fade_engine import pfe_pkg::*; #(
  parameter int PALETTE_ENTRIES = PFE_PALETTE_ENTRIES
) (
  input  wire        clk,
  input  wire        rst_n,
  pfe_in_if.sink     in_chan,
  pfe_out_if.source  out_chan,
  pfe_cfg_if.sink    cfg_chan
);

  localparam int DEPTH = 4 * PALETTE_ENTRIES;
  localparam int AW = $clog2(DEPTH);
  // Entries of a bank that a span may reach
  localparam int SPAN_LIMIT = (PALETTE_ENTRIES < SPAN_CAP) ? PALETTE_ENTRIES : SPAN_CAP;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_RDWAIT = 6'b000010,
    ST_FILL   = 6'b000100,
    ST_WALK   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  function automatic logic [AW-1:0] bank_base(input logic [1:0] b);
    return AW'(AW'(b) * AW'(PALETTE_ENTRIES));
  endfunction

  // Palette store: one write port, two registered read ports (working, target)
  rgb_t mem [DEPTH];

  state_t         state_r, state_nxt;
  mode_t          mode_r, mode_nxt;
  logic [4:0]     step_count_r, step_count_nxt;
  logic [5:0]     span_first_r, span_first_nxt;
  logic [5:0]     span_off_r, span_off_nxt;
  logic           dual_bank_r;
  logic [6:0]     e_r, e_nxt;
  logic           bank_hi_r, bank_hi_nxt;
  logic           p_v_r, p_v_nxt;
  logic [AW-1:0]  p_addr_r, p_addr_nxt;
  rgb_t           rd_w_r, rd_t_r;
  logic           rd_ok_r, rd_ok_nxt;
  logic           res_done_r, res_done_nxt;
  rgb_t           res_rgb_r, res_rgb_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_done_r, out_done_nxt;
  rgb_t           out_rgb_r, out_rgb_nxt;

  logic           in_acc;
  logic           out_free;
  logic [6:0]     span_last;
  logic           issue_ok;
  logic           bank_b_on;
  logic           idx_ok;
  logic [AW-1:0]  walk_addr;
  logic [AW-1:0]  ra_addr, rb_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  rgb_t           mem_wd;
  rgb_t           stepped;
  rgb_t           fill_rgb;
  rgb_t           load_rgb;

  pfe_step_unit u_step (
    .mode    (mode_r),
    .work    (rd_w_r),
    .target  (rd_t_r),
    .stepped (stepped)
  );

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.done_res  = out_done_r;
  assign out_chan.red_out   = out_rgb_r.red;
  assign out_chan.green_out = out_rgb_r.green;
  assign out_chan.blue_out  = out_rgb_r.blue;
  assign out_free = !out_valid_r || out_chan.ready;

  // Span end may run past the bank; stop at whichever comes first
  assign span_last = {1'b0, span_first_r} + {1'b0, span_off_r};
  assign issue_ok  = (e_r <= span_last) && (e_r < 7'(SPAN_LIMIT));
  assign bank_b_on = (mode_r == MODE_FADE_OUT) || (mode_r == MODE_FLASH_OUT) || dual_bank_r;
  assign idx_ok    = (int'(in_chan.entry_index) < PALETTE_ENTRIES);

  assign walk_addr = bank_base(bank_hi_r ? BANK_WORK_B : BANK_WORK_A) + AW'(e_r[5:0]);
  assign ra_addr   = (state_r == ST_IDLE) ? bank_base(in_chan.bank) + AW'(in_chan.entry_index)
                                          : walk_addr;
  // Target palette sits one bank above its working palette
  assign rb_addr   = ra_addr + AW'(PALETTE_ENTRIES);

  assign fill_rgb = (mode_r == MODE_FADE_IN) ? rgb_t'('0) : rgb_t'{red: CH_WHITE,
                                                                   green: CH_WHITE,
                                                                   blue: CH_WHITE};
  assign load_rgb = '{red: in_chan.red_in, green: in_chan.green_in, blue: in_chan.blue_in};

  // Store write port: load on accept, span fill, or walk write-back
  always_comb begin
    mem_we = 1'b0;
    mem_wa = walk_addr;
    mem_wd = stepped;
    if (p_v_r) begin
      mem_we = 1'b1;
      mem_wa = p_addr_r;
      mem_wd = stepped;
    end else if (state_r == ST_FILL) begin
      mem_we = issue_ok;
      mem_wa = AW'(e_r[5:0]);
      mem_wd = fill_rgb;
    end else if (in_acc && (in_chan.func == FUNC_LOAD)) begin
      mem_we = idx_ok;
      mem_wa = ra_addr;
      mem_wd = load_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_w_r <= mem[ra_addr];
    rd_t_r <= mem[rb_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    step_count_nxt = step_count_r;
    span_first_nxt = span_first_r;
    span_off_nxt   = span_off_r;
    e_nxt          = e_r;
    bank_hi_nxt    = bank_hi_r;
    p_v_nxt        = 1'b0;
    p_addr_nxt     = p_addr_r;
    rd_ok_nxt      = rd_ok_r;
    res_done_nxt   = res_done_r;
    res_rgb_nxt    = res_rgb_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_done_nxt   = out_done_r;
    out_rgb_nxt    = out_rgb_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_rgb_nxt  = '0;
          res_done_nxt = (mode_r == MODE_IDLE);
          case (in_chan.func)
            FUNC_LOAD: begin
              state_nxt = ST_FINISH;
            end
            FUNC_READ: begin
              rd_ok_nxt = idx_ok;
              state_nxt = ST_RDWAIT;
            end
            FUNC_START: begin
              res_done_nxt   = 1'b0;
              step_count_nxt = 5'd0;
              span_first_nxt = 6'd0;
              span_off_nxt   = FULL_SPAN_OFFSET;
              e_nxt          = 7'd0;
              state_nxt      = ST_FINISH;
              case (in_chan.mode_sel)
                SEL_FADE_IN: begin
                  mode_nxt       = MODE_FADE_IN;
                  span_first_nxt = in_chan.range_first;
                  span_off_nxt   = in_chan.range_last_offset;
                  e_nxt          = {1'b0, in_chan.range_first};
                  state_nxt      = ST_FILL;
                end
                SEL_FADE_OUT: begin
                  mode_nxt = MODE_FADE_OUT;
                end
                SEL_FLASH_IN: begin
                  mode_nxt  = MODE_FLASH_IN;
                  state_nxt = ST_FILL;
                end
                SEL_FLASH_OUT: begin
                  mode_nxt = MODE_FLASH_OUT;
                end
                default: begin
                  mode_nxt = MODE_IDLE;
                end
              endcase
            end
            FUNC_TICK: begin
              if (mode_r == MODE_IDLE) begin
                res_done_nxt = 1'b1;
                state_nxt    = ST_FINISH;
              end else begin
                e_nxt       = {1'b0, span_first_r};
                bank_hi_nxt = 1'b0;
                state_nxt   = ST_WALK;
              end
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        // Read data lands this cycle; out-of-range indexes answer black
        res_rgb_nxt = rd_ok_r ? rd_w_r : '0;
        state_nxt   = ST_FINISH;
      end
      ST_FILL: begin
        if (issue_ok) begin
          e_nxt = e_r + 7'd1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_WALK: begin
        // Issue one entry a cycle; its write-back follows in the next cycle
        if (issue_ok) begin
          p_v_nxt    = 1'b1;
          p_addr_nxt = walk_addr;
          e_nxt      = e_r + 7'd1;
        end else if (!bank_hi_r && bank_b_on) begin
          bank_hi_nxt = 1'b1;
          e_nxt       = {1'b0, span_first_r};
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Last write-back has retired; advance the step count, or end the mode at the last step
        if (step_count_r == LAST_STEP) begin
          step_count_nxt = 5'd0;
          mode_nxt       = MODE_IDLE;
          res_done_nxt   = 1'b1;
        end else begin
          step_count_nxt = step_count_r + 5'd1;
          res_done_nxt   = 1'b0;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_done_nxt  = res_done_r;
          out_rgb_nxt   = res_rgb_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_IDLE;
      step_count_r <= 5'd0;
      span_first_r <= 6'd0;
      span_off_r   <= FULL_SPAN_OFFSET;
      dual_bank_r  <= 1'b1;
      p_v_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      step_count_r <= step_count_nxt;
      span_first_r <= span_first_nxt;
      span_off_r   <= span_off_nxt;
      p_v_r        <= p_v_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        dual_bank_r <= cfg_chan.dual_bank_enable;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    bank_hi_r  <= bank_hi_nxt;
    p_addr_r   <= p_addr_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_done_r <= res_done_nxt;
    res_rgb_r  <= res_rgb_nxt;
    out_done_r <= out_done_nxt;
    out_rgb_r  <= out_rgb_nxt;
  end

`ifndef SYNTHESIS
  // No write-back may be left in flight once the sequencer takes a new word
  a_no_pending_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !p_v_r)
    else $error("write-back pending while idle");

  // Step count never passes the last step
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_count_r <= LAST_STEP)
    else $error("step count out of range");

  // With no mode active the step count rests at zero
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (step_count_r == 5'd0))
    else $error("step count nonzero while idle");

  // Drain leads straight to the result stage with the pipeline empty
  a_drain_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> ((state_r == ST_FINISH) && !p_v_r))
    else $error("drain did not retire the walk");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for the palette fade engine: directed script, then random fade traffic.
`timescale 1ns / 100ps

module tb_top;
  import pfe_pkg::*;

  // Target banks have no name in the package
  localparam logic [1:0] BANK_TGT_A = 2'd1;
  localparam logic [1:0] BANK_TGT_B = 2'd3;

  localparam int DRAIN_CYCLES = 150;       // a full-span tick plus margin
  localparam int HOLD_CYCLES  = 400;       // long receiver hold-off
  localparam int TIMEOUT_NS   = 5_000_000;

  // Random phases: dual-bank setting, idling of each side, word count at which to stop
  localparam logic PHASE_DUAL [3] = '{1'b0, 1'b1, 1'b0};
  localparam int SEND_IDLE [3] = '{14, 60, 0};
  localparam int RECV_IDLE [3] = '{60, 14, 0};
  localparam int PHASE_END [3] = '{669, 1059, 1450};
  localparam int PAUSE_AT = 860;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] bank;
    logic [5:0] entry_index;
    rgb_t       colour;
    logic [1:0] mode_sel;
    logic [5:0] range_first;
    logic [5:0] range_last_offset;
  } pal_word_t;

  typedef struct packed {
    logic done;
    rgb_t colour;
  } pal_result_t;

  typedef struct packed {
    pal_word_t   word;
    logic        typed;   // 1: take the result below, 0: take the prediction
    pal_result_t want;
  } script_row_t;

  // Directed script. Every entry a tick or read touches is written before it is used.
  localparam int SCRIPT_LEN = 23;
  localparam script_row_t FADE_SCRIPT [SCRIPT_LEN] = '{
    // tick while idle
    '{'{FUNC_TICK,  BANK_WORK_A, 6'd0,  24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b1, 24'h000000}},
    // extremes of colour and index, read back
    '{'{FUNC_LOAD,  BANK_WORK_A, 6'd0,  24'hFFFFFF, SEL_FADE_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b1, 24'h000000}},
    '{'{FUNC_READ,  BANK_WORK_A, 6'd0,  24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b1, 24'hFFFFFF}},
    '{'{FUNC_LOAD,  BANK_TGT_B,  6'd63, 24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b1, 24'h000000}},
    '{'{FUNC_READ,  BANK_TGT_B,  6'd63, 24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b1, 24'h000000}},
    // targets and working B for the top two entries
    '{'{FUNC_LOAD,  BANK_TGT_A,  6'd62, 24'hE020FF, SEL_FADE_IN, 6'd0, 6'd0}, 1'b0, '0},
    '{'{FUNC_LOAD,  BANK_TGT_A,  6'd63, 24'h00FF40, SEL_FADE_IN, 6'd0, 6'd0}, 1'b0, '0},
    '{'{FUNC_LOAD,  BANK_WORK_B, 6'd62, 24'hFF0080, SEL_FADE_IN, 6'd0, 6'd0}, 1'b0, '0},
    '{'{FUNC_LOAD,  BANK_WORK_B, 6'd63, 24'h10E000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b0, '0},
    '{'{FUNC_LOAD,  BANK_TGT_B,  6'd62, 24'h0000FF, SEL_FADE_IN, 6'd0, 6'd0}, 1'b0, '0},
    // every start; done drops while a mode is active
    '{'{FUNC_START, BANK_WORK_A, 6'd0,  24'h000000, SEL_FADE_OUT, 6'd0, 6'd0}, 1'b1,
      '{1'b0, 24'h000000}},
    '{'{FUNC_LOAD,  BANK_WORK_A, 6'd1,  24'hAA5501, SEL_FADE_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b0, 24'h000000}},
    '{'{FUNC_START, BANK_WORK_A, 6'd0,  24'h000000, SEL_FLASH_OUT, 6'd0, 6'd0}, 1'b1,
      '{1'b0, 24'h000000}},
    '{'{FUNC_START, BANK_WORK_A, 6'd0,  24'h000000, SEL_FLASH_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b0, 24'h000000}},
    '{'{FUNC_READ,  BANK_WORK_A, 6'd63, 24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b0, 24'hE0E0E0}},
    '{'{FUNC_READ,  BANK_WORK_A, 6'd1,  24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b0, 24'hE0E0E0}},
    // fade-in whose range runs past the last entry
    '{'{FUNC_START, BANK_WORK_A, 6'd0,  24'h000000, SEL_FADE_IN, 6'd62, 6'd63}, 1'b1,
      '{1'b0, 24'h000000}},
    '{'{FUNC_READ,  BANK_WORK_A, 6'd62, 24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b0, 24'h000000}},
    '{'{FUNC_TICK,  BANK_WORK_A, 6'd0,  24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b0, '0},
    '{'{FUNC_TICK,  BANK_WORK_A, 6'd0,  24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b0, '0},
    '{'{FUNC_READ,  BANK_WORK_A, 6'd62, 24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b0, '0},
    '{'{FUNC_READ,  BANK_WORK_B, 6'd63, 24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b0, '0},
    '{'{FUNC_READ,  BANK_TGT_A,  6'd62, 24'h000000, SEL_FADE_IN, 6'd0, 6'd0}, 1'b1,
      '{1'b0, 24'hE020FF}}
  };

  logic clk;
  logic rst_n;

  pfe_in_if  in_bus ();
  pfe_out_if out_bus ();
  pfe_cfg_if cfg_bus ();

  palette_fade_engine DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // Mirror of the block's state, advanced once per accepted word
  rgb_t       palette_mirror [0:4*PFE_PALETTE_ENTRIES-1];
  mode_t      fade_mode;
  logic [4:0] step_count;
  logic [5:0] span_first;
  logic [5:0] span_off;
  logic       dual_bank;

  pal_result_t pending_results [$];
  int          mismatch_count = 0;
  int          words_sent;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;

  // Move one channel toward the target: blue first, then green, then red
  function automatic rgb_t nudge_toward(rgb_t w, rgb_t t, logic up);
    rgb_t r;
    r = w;
    if (up) begin
      if (t.blue > w.blue) r.blue = w.blue + CH_STEP;
      else if (t.green > w.green) r.green = w.green + CH_STEP;
      else if (t.red > w.red) r.red = w.red + CH_STEP;
    end else begin
      if (t.blue < w.blue) r.blue = w.blue - CH_STEP;
      else if (t.green < w.green) r.green = w.green - CH_STEP;
      else if (t.red < w.red) r.red = w.red - CH_STEP;
    end
    return r;
  endfunction

  // Move the first channel, red first, that has not reached the goal
  function automatic rgb_t nudge_out(rgb_t w, logic [7:0] goal, logic up);
    rgb_t r;
    r = w;
    if (w.red != goal) r.red = up ? w.red + CH_STEP : w.red - CH_STEP;
    else if (w.green != goal) r.green = up ? w.green + CH_STEP : w.green - CH_STEP;
    else if (w.blue != goal) r.blue = up ? w.blue + CH_STEP : w.blue - CH_STEP;
    return r;
  endfunction

  // Walk the span of one working bank; entries past the end are dropped
  function automatic void step_span(logic [1:0] bank);
    int i;
    int wi;
    int ti;
    for (i = 0; i <= int'(span_off) && int'(span_first) + i < SPAN_CAP; i++) begin
      wi = int'(bank) * PFE_PALETTE_ENTRIES + int'(span_first) + i;
      ti = wi + PFE_PALETTE_ENTRIES;
      case (fade_mode)
        MODE_FADE_IN:  palette_mirror[wi] = nudge_toward(palette_mirror[wi],
                                                         palette_mirror[ti], 1'b1);
        MODE_FLASH_IN: palette_mirror[wi] = nudge_toward(palette_mirror[wi],
                                                         palette_mirror[ti], 1'b0);
        MODE_FADE_OUT: palette_mirror[wi] = nudge_out(palette_mirror[wi], 8'd0, 1'b0);
        default:       palette_mirror[wi] = nudge_out(palette_mirror[wi], CH_WHITE, 1'b1);
      endcase
    end
  endfunction

  function automatic void fill_span(rgb_t c);
    int i;
    for (i = 0; i <= int'(span_off) && int'(span_first) + i < SPAN_CAP; i++)
      palette_mirror[int'(span_first) + i] = c;
  endfunction

  // Work out the result of one word and advance the mirror
  function automatic pal_result_t predict_fade(pal_word_t w);
    pal_result_t res;
    int slot;
    res = '0;
    slot = int'(w.bank) * PFE_PALETTE_ENTRIES + int'(w.entry_index);
    case (w.func)
      FUNC_LOAD: begin
        if (int'(w.entry_index) < PFE_PALETTE_ENTRIES) palette_mirror[slot] = w.colour;
        res.done = (fade_mode == MODE_IDLE);
      end
      FUNC_START: begin
        step_count = '0;
        span_first = '0;
        span_off = FULL_SPAN_OFFSET;
        case (w.mode_sel)
          SEL_FADE_IN: begin
            fade_mode = MODE_FADE_IN;
            span_first = w.range_first;
            span_off = w.range_last_offset;
            fill_span('0);
          end
          SEL_FADE_OUT: fade_mode = MODE_FADE_OUT;
          SEL_FLASH_IN: begin
            fade_mode = MODE_FLASH_IN;
            fill_span({CH_WHITE, CH_WHITE, CH_WHITE});
          end
          default: fade_mode = MODE_FLASH_OUT;
        endcase
        res.done = 1'b0;
      end
      FUNC_TICK: begin
        if (fade_mode == MODE_IDLE) begin
          res.done = 1'b1;
        end else begin
          step_span(BANK_WORK_A);
          // bank B always follows the outward modes, the inward ones only when enabled
          if (fade_mode == MODE_FADE_OUT || fade_mode == MODE_FLASH_OUT || dual_bank)
            step_span(BANK_WORK_B);
          step_count = step_count + 5'd1;
          if (step_count > LAST_STEP) begin
            step_count = '0;
            fade_mode = MODE_IDLE;
            res.done = 1'b1;
          end
        end
      end
      default: begin
        if (int'(w.entry_index) < PFE_PALETTE_ENTRIES) res.colour = palette_mirror[slot];
        res.done = (fade_mode == MODE_IDLE);
      end
    endcase
    return res;
  endfunction

  // Colours favour multiples of 32, white and the extremes so that fades meet their goals
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 7) * 32);
      1:       return CH_WHITE;
      2:       return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pal_word_t random_word();
    pal_word_t w;
    w.func = 2'($urandom_range(0, 3));
    w.bank = 2'($urandom_range(0, 3));
    w.entry_index = 6'($urandom_range(0, 63));
    w.colour = {pick_channel(), pick_channel(), pick_channel()};
    w.mode_sel = 2'($urandom_range(0, 3));
    w.range_first = 6'($urandom_range(0, 63));
    w.range_last_offset = 6'($urandom_range(0, 63));
    return w;
  endfunction

  // Offer one word, idling at random first; return at the accepting edge
  task automatic offer_word(input pal_word_t w, input logic typed, input pal_result_t want);
    pal_result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid             <= 1'b1;
    in_bus.func              <= w.func;
    in_bus.bank              <= w.bank;
    in_bus.entry_index       <= w.entry_index;
    in_bus.red_in            <= w.colour.red;
    in_bus.green_in          <= w.colour.green;
    in_bus.blue_in           <= w.colour.blue;
    in_bus.mode_sel          <= w.mode_sel;
    in_bus.range_first       <= w.range_first;
    in_bus.range_last_offset <= w.range_last_offset;
    do @(posedge clk); while (!in_bus.ready);
    predicted = predict_fade(w);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // Drop valid, wait for every expected result, then hold for a further stretch
  task automatic settle(input int extra);
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_dual_bank(input logic enable);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.dual_bank_enable <= enable;
    do @(posedge clk); while (!cfg_bus.ready);
    dual_bank = enable;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Start a mode, then tick it, often through to done, with loads and reads mixed in;
  // now and then abandon the sequence part way so the next start cuts in
  task automatic run_fade_sequence();
    pal_word_t w;
    int n_ticks;
    int k;
    w = random_word();
    w.func = FUNC_START;
    if ($urandom_range(0, 9) < 7) w.range_last_offset = 6'($urandom_range(0, 7));
    else if ($urandom_range(0, 1) == 1) w.range_last_offset = FULL_SPAN_OFFSET;
    offer_word(w, 1'b0, '0);
    n_ticks = $urandom_range(20, 24);
    for (k = 0; k < n_ticks; k++) begin
      if ($urandom_range(0, 99) < 2) return;
      if ($urandom_range(0, 9) < 2) begin
        w = random_word();
        w.func = $urandom_range(0, 1) ? FUNC_LOAD : FUNC_READ;
        offer_word(w, 1'b0, '0);
      end
      w = random_word();
      w.func = FUNC_TICK;
      offer_word(w, 1'b0, '0);
    end
    for (k = $urandom_range(1, 3); k > 0; k--) begin
      w = random_word();
      w.func = FUNC_READ;
      offer_word(w, 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop should the block hang
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : result_check
    pal_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: done %0d rgb %h%h%h", out_bus.done_res,
               out_bus.red_out, out_bus.green_out, out_bus.blue_out);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_bus.done_res !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, out_bus.done_res);
          mismatch_count++;
        end
        if (out_bus.red_out !== want.colour.red) begin
          $error("red_out: expected %0d, got %0d", want.colour.red, out_bus.red_out);
          mismatch_count++;
        end
        if (out_bus.green_out !== want.colour.green) begin
          $error("green_out: expected %0d, got %0d", want.colour.green, out_bus.green_out);
          mismatch_count++;
        end
        if (out_bus.blue_out !== want.colour.blue) begin
          $error("blue_out: expected %0d, got %0d", want.colour.blue, out_bus.blue_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    pal_word_t w;
    int r;
    int ph;
    int b;
    int e;
    logic sender_paused;

    // Drive every input to a known value and hold reset
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.func = FUNC_LOAD;
    in_bus.bank = BANK_WORK_A;
    in_bus.entry_index = '0;
    in_bus.red_in = '0;
    in_bus.green_in = '0;
    in_bus.blue_in = '0;
    in_bus.mode_sel = SEL_FADE_IN;
    in_bus.range_first = '0;
    in_bus.range_last_offset = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.dual_bank_enable = 1'b1;
    hold_req = 1'b0;
    sender_paused = 1'b0;
    words_sent = 0;
    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];

    // Mirror after reset; the store has no reset and is never read before written
    fade_mode = MODE_IDLE;
    step_count = '0;
    span_first = '0;
    span_off = FULL_SPAN_OFFSET;
    dual_bank = 1'b1;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    write_dual_bank(1'b1);
    for (r = 0; r < SCRIPT_LEN; r++)
      offer_word(FADE_SCRIPT[r].word, FADE_SCRIPT[r].typed, FADE_SCRIPT[r].want);

    for (ph = 0; ph < 3; ph++) begin
      // Change the register only once the block has gone quiet
      settle(DRAIN_CYCLES);
      write_dual_bank(PHASE_DUAL[ph]);
      send_idle_pct = SEND_IDLE[ph];
      recv_idle_pct = RECV_IDLE[ph];
      if (ph == 0) begin
        // Fill the whole store so that any tick or read sees written entries
        for (b = 0; b < 4; b++) begin
          for (e = 0; e < PFE_PALETTE_ENTRIES; e++) begin
            w = random_word();
            w.func = FUNC_LOAD;
            w.bank = 2'(b);
            w.entry_index = 6'(e);
            offer_word(w, 1'b0, '0);
          end
        end
        // Stall the result side for a long stretch while the sender keeps offering words
        hold_req = 1'b1;
      end
      while (words_sent < PHASE_END[ph]) begin
        if (ph == 1 && !sender_paused && words_sent >= PAUSE_AT) begin
          settle(0);
          sender_paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 8) begin
          run_fade_sequence();
        end else begin
          for (r = $urandom_range(1, 4); r > 0; r--) offer_word(random_word(), 1'b0, '0);
        end
      end
    end

    settle(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
